### rtl/scbi_pkg.sv
// Shared constants, types and helpers of the size class bitmap index.
`timescale 1ns / 1ps

package scbi_pkg;

  // Fixed geometry.
  localparam int WORD_BITS = 64;
  localparam int WBIT_W = 6;
  localparam int SIZE_W = 8;
  localparam int SLOT_W = 12;
  localparam int MODE_W = 2;
  localparam int OCC_WORDS = 4;
  localparam int OCC_BITS = OCC_WORDS * WORD_BITS;
  localparam int OCC_WIDX_W = 2;

  // Stream payload widths.
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 24;

  // Parameter defaults.
  localparam int DEF_NUM_SIZES = 256;
  localparam int DEF_ADDR_WORDS = 64;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW_WR,
    ST_F_OCC,
    ST_F_ENC,
    ST_F_SUM,
    ST_F_LEAF,
    ST_RESP
  } state_e;

  // Occupancy update request.
  typedef struct packed {
    logic set;
    logic clr;
    logic [SIZE_W-1:0] cls;
  } occ_cmd_t;

  // Occupancy search answer: first non-empty masked word.
  typedef struct packed {
    logic hit;
    logic [OCC_WIDX_W-1:0] widx;
    logic [WORD_BITS-1:0] word;
  } occ_stat_t;

  // Index of the lowest set bit; zero for an empty word.
  function automatic logic [WBIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] w);
    logic [WBIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = WBIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/scbi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module scbi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/scbi_occ.sv
// Class occupancy bits with set/clear and masked first-word search.
`timescale 1ns / 1ps

module scbi_occ
  import scbi_pkg::*;
#(
  parameter int NUM_SIZES = DEF_NUM_SIZES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  occ_cmd_t          cmd_i,
  input  logic [SIZE_W-1:0] req_i,
  output occ_stat_t         stat_o
);

  localparam int CLS_W = (NUM_SIZES > 1) ? $clog2(NUM_SIZES) : 1;

  logic [NUM_SIZES-1:0] occ_q;
  logic [OCC_BITS-1:0]  occ_full;
  logic [WORD_BITS-1:0] masked [OCC_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (cmd_i.set) begin
      occ_q[cmd_i.cls[CLS_W-1:0]] <= 1'b1;
    end else if (cmd_i.clr) begin
      occ_q[cmd_i.cls[CLS_W-1:0]] <= 1'b0;
    end
  end

  assign occ_full = OCC_BITS'(occ_q);

  // Drop classes below the request.
  always_comb begin
    for (int w = 0; w < OCC_WORDS; w++) begin
      if (OCC_WIDX_W'(w) < req_i[SIZE_W-1 -: OCC_WIDX_W]) begin
        masked[w] = '0;
      end else if (OCC_WIDX_W'(w) == req_i[SIZE_W-1 -: OCC_WIDX_W]) begin
        masked[w] = occ_full[w*WORD_BITS +: WORD_BITS] &
                    ({WORD_BITS{1'b1}} << req_i[WBIT_W-1:0]);
      end else begin
        masked[w] = occ_full[w*WORD_BITS +: WORD_BITS];
      end
    end
  end

  // Pick the lowest non-empty word.
  always_comb begin
    stat_o = '0;
    for (int w = OCC_WORDS - 1; w >= 0; w--) begin
      if (|masked[w]) begin
        stat_o.hit  = 1'b1;
        stat_o.widx = OCC_WIDX_W'(w);
        stat_o.word = masked[w];
      end
    end
  end

endmodule

### rtl/size_class_bitmap_index_top.sv
// Top level of the size class bitmap index: sequencer, summary and leaf memories.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                       | Payload
// s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata: mode[1:0] size_in[9:2] addr_in[21:10]
// m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata: size_out[7:0] addr_out[19:8];
//          |     |                                 | tuser: found
//
// Insert and remove launch the leaf and summary reads at the transfer, then pass
// through a write-back state and the result hand-over.
// Find steps through occupancy search, class encode with summary read, leaf read,
// leaf encode and result hand-over; a miss or an out-of-range item skips to the hand-over.
// After reset a clearing pass zeroes both memories, walking every leaf address;
// s_axis_tready_o stays low until it ends.
// A result waits in the output register while the next transfer is taken;
// only a result that finds the output register still full stalls the sequencer.

module size_class_bitmap_index_top
  import scbi_pkg::*;
#(
  parameter int NUM_SIZES  = DEF_NUM_SIZES,
  parameter int ADDR_WORDS = DEF_ADDR_WORDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // mode, size_in, addr_in, zero pad
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // size_out, addr_out, zero pad
  output logic                  m_axis_tuser_o    // found
);

  localparam int CLS_W      = (NUM_SIZES > 1) ? $clog2(NUM_SIZES) : 1;
  localparam int LEAF_DEPTH = NUM_SIZES * ADDR_WORDS;
  localparam int LEAF_AW    = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
  localparam int NUM_SLOTS  = ADDR_WORDS * WORD_BITS;

  function automatic logic [LEAF_AW-1:0] leaf_idx(input logic [SIZE_W-1:0] c,
                                                  input logic [WBIT_W-1:0] a);
    return LEAF_AW'(int'(c) * ADDR_WORDS + int'(a));
  endfunction

  state_e state_q, state_d;

  // Input unpack.
  logic [MODE_W-1:0] in_mode;
  logic [SIZE_W-1:0] in_size;
  logic [SLOT_W-1:0] in_addr;
  logic              in_ok;
  logic              in_xfer;

  assign in_mode = s_axis_tdata_i[MODE_W-1:0];
  assign in_size = s_axis_tdata_i[MODE_W +: SIZE_W];
  assign in_addr = s_axis_tdata_i[MODE_W+SIZE_W +: SLOT_W];
  assign in_ok   = (32'(in_size) < NUM_SIZES) && (32'(in_addr) < NUM_SLOTS);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // Held item and find progress.
  logic [MODE_W-1:0]     mode_q;
  logic [SIZE_W-1:0]     size_q;
  logic [SLOT_W-1:0]     addr_q;
  logic [LEAF_AW-1:0]    clr_cnt_q;
  logic [OCC_WIDX_W-1:0] widx_q;
  logic [WORD_BITS-1:0]  wword_q;
  logic [SIZE_W-1:0]     cls_q;
  logic [WBIT_W-1:0]     aw_q;

  // Result staging and output register.
  logic              res_found_q;
  logic [SIZE_W-1:0] res_size_q;
  logic [SLOT_W-1:0] res_addr_q;
  logic              out_valid_q;
  logic              out_found_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [SLOT_W-1:0] out_addr_q;
  logic              out_load;

  // Memory ports.
  logic                 leaf_we, leaf_re, sum_we, sum_re;
  logic [LEAF_AW-1:0]   leaf_waddr, leaf_raddr;
  logic [CLS_W-1:0]     sum_waddr, sum_raddr;
  logic [WORD_BITS-1:0] leaf_wdata, leaf_rdata, sum_wdata, sum_rdata;

  occ_cmd_t  occ_cmd;
  occ_stat_t occ_stat;

  // Derived per-state values.
  logic [WORD_BITS-1:0] slot_mask, word_mask, leaf_new, sum_new;
  logic [SIZE_W-1:0]    cls_enc;
  logic                 cls_ok;
  logic [WBIT_W-1:0]    aw_enc;
  logic                 sum_ok;
  logic                 req_ok;
  logic                 clr_last;

  assign slot_mask = WORD_BITS'(1) << addr_q[WBIT_W-1:0];
  assign word_mask = WORD_BITS'(1) << addr_q[SLOT_W-1 -: WBIT_W];
  assign cls_enc   = {widx_q, low_bit(wword_q)};
  assign cls_ok    = 32'(cls_enc) < NUM_SIZES;
  assign aw_enc    = low_bit(sum_rdata);
  assign sum_ok    = (|sum_rdata) && (32'(aw_enc) < ADDR_WORDS);
  assign req_ok    = 32'(size_q) < NUM_SIZES;
  assign clr_last  = (clr_cnt_q == LEAF_AW'(LEAF_DEPTH - 1));
  assign out_load  = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready_i);

  scbi_occ #(
    .NUM_SIZES(NUM_SIZES)
  ) u_occ (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (occ_cmd),
    .req_i (size_q),
    .stat_o(occ_stat)
  );

  scbi_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NUM_SIZES)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sum_we),
    .waddr_i(sum_waddr),
    .wdata_i(sum_wdata),
    .re_i   (sum_re),
    .raddr_i(sum_raddr),
    .rdata_o(sum_rdata)
  );

  scbi_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(LEAF_DEPTH)
  ) u_leaf_ram (
    .clk_i  (clk_i),
    .we_i   (leaf_we),
    .waddr_i(leaf_waddr),
    .wdata_i(leaf_wdata),
    .re_i   (leaf_re),
    .raddr_i(leaf_raddr),
    .rdata_o(leaf_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_mode)
            MODE_INSERT, MODE_REMOVE: state_d = in_ok ? ST_RMW_WR : ST_RESP;
            MODE_FIND:                state_d = ST_F_OCC;
            default:                  state_d = ST_RESP;
          endcase
        end
      end
      ST_RMW_WR: state_d = ST_RESP;
      ST_F_OCC:  state_d = (req_ok && occ_stat.hit) ? ST_F_ENC : ST_RESP;
      ST_F_ENC:  state_d = cls_ok ? ST_F_SUM : ST_RESP;
      ST_F_SUM:  state_d = sum_ok ? ST_F_LEAF : ST_RESP;
      ST_F_LEAF: state_d = ST_RESP;
      ST_RESP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory and occupancy controls.
  always_comb begin
    leaf_re    = 1'b0;
    leaf_raddr = leaf_idx(in_size, in_addr[SLOT_W-1 -: WBIT_W]);
    leaf_we    = 1'b0;
    leaf_waddr = leaf_idx(size_q, addr_q[SLOT_W-1 -: WBIT_W]);
    leaf_wdata = '0;
    sum_re     = 1'b0;
    sum_raddr  = in_size[CLS_W-1:0];
    sum_we     = 1'b0;
    sum_waddr  = size_q[CLS_W-1:0];
    sum_wdata  = '0;
    occ_cmd    = '0;
    occ_cmd.cls = size_q;
    leaf_new   = leaf_rdata | slot_mask;
    sum_new    = sum_rdata | word_mask;
    case (state_q)
      ST_CLEAR: begin
        leaf_we    = 1'b1;
        leaf_waddr = clr_cnt_q;
        sum_we     = 32'(clr_cnt_q) < NUM_SIZES;
        sum_waddr  = clr_cnt_q[CLS_W-1:0];
      end
      ST_IDLE: begin
        // Launch the leaf and summary reads straight from the transfer.
        leaf_re = in_xfer && in_ok && (in_mode == MODE_INSERT || in_mode == MODE_REMOVE);
        sum_re  = leaf_re;
      end
      ST_RMW_WR: begin
        if (mode_q == MODE_INSERT) begin
          if ((leaf_rdata & slot_mask) == '0) begin
            leaf_we     = 1'b1;
            leaf_wdata  = leaf_new;
            sum_we      = 1'b1;
            sum_wdata   = sum_new;
            occ_cmd.set = 1'b1;
          end
        end else begin
          leaf_new   = leaf_rdata & ~slot_mask;
          sum_new    = sum_rdata & ~word_mask;
          leaf_we    = 1'b1;
          leaf_wdata = leaf_new;
          // Clear upper levels once the word empties.
          if (leaf_new == '0) begin
            sum_we      = 1'b1;
            sum_wdata   = sum_new;
            occ_cmd.clr = (sum_new == '0);
          end
        end
      end
      ST_F_ENC: begin
        sum_re    = cls_ok;
        sum_raddr = cls_enc[CLS_W-1:0];
      end
      ST_F_SUM: begin
        leaf_re    = sum_ok;
        leaf_raddr = leaf_idx(cls_q, aw_enc);
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + LEAF_AW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q      <= in_mode;
      size_q      <= in_size;
      addr_q      <= in_addr;
      res_found_q <= 1'b0;
      res_size_q  <= '0;
      res_addr_q  <= '0;
    end
    if (state_q == ST_F_OCC) begin
      widx_q  <= occ_stat.widx;
      wword_q <= occ_stat.word;
    end
    if (state_q == ST_F_ENC) begin
      cls_q <= cls_enc;
    end
    if (state_q == ST_F_SUM) begin
      aw_q <= aw_enc;
    end
    if (state_q == ST_F_LEAF) begin
      res_found_q <= 1'b1;
      res_size_q  <= cls_q;
      res_addr_q  <= {aw_q, low_bit(leaf_rdata)};
    end
    if (out_load) begin
      out_found_q <= res_found_q;
      out_size_q  <= res_size_q;
      out_addr_q  <= res_addr_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_found_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_addr_q, out_size_q});

  // Checks.
  a_xfer_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (state_q == ST_IDLE) && $past(state_q != ST_CLEAR || clr_last))
    else $error("transfer taken outside idle");

  a_no_write_find : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F_OCC || state_q == ST_F_ENC || state_q == ST_F_SUM ||
     state_q == ST_F_LEAF) |-> !leaf_we && !sum_we && !occ_cmd.set && !occ_cmd.clr)
    else $error("store written during find");

  a_leaf_word_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F_LEAF) |-> (32'(aw_q) < ADDR_WORDS) && (32'(cls_q) < NUM_SIZES))
    else $error("find reached leaf with word or class out of range");

  a_found_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (32'(m_axis_tdata_o[SIZE_W-1:0]) < NUM_SIZES))
    else $error("found class beyond configured classes");

endmodule
